>>> hdl/tcrr_pkg.sv
package tcrr_pkg;

    localparam int COLUMNS_DEF = 21;
    localparam int ROWS        = 15;

    localparam int CAM_W    = 16;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int FINE_W   = 4;
    localparam int TAG_W    = 8;
    localparam int BUDGET_W = 6;
    localparam int SPRITE_W = 9;
    localparam int MAPCOL_W = 13;
    localparam int WORD_W   = 16;
    localparam int POS_W    = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;

    localparam logic [BUDGET_W-1:0] BUDGET_RST = BUDGET_W'(10);
    localparam logic [SPRITE_W-1:0] SPRITE_RST = SPRITE_W'(1);
    localparam logic [POS_W-1:0]    Y_BASE     = POS_W'(496);
    localparam logic [6:0]          ROWS_FIELD = 7'(ROWS & 'h3F);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELOAD_BUDGET = 4'd0,
        CFG_FIRST_SPRITE  = 4'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic [CAM_W-1:0] camera_x;
        logic [CAM_W-1:0] camera_y;
        logic [TAG_W-1:0] level_tag;
        logic [TAG_W-1:0] doors_open;
    } t_in_item;

    typedef struct packed {
        logic                reload;
        logic                visible;
        logic [SPRITE_W-1:0] sprite_number;
        logic [MAPCOL_W-1:0] map_column;
        logic [ROW_W-1:0]    map_row;
        logic [WORD_W-1:0]   y_word;
        logic [WORD_W-1:0]   x_word;
        logic                last;
    } t_out_item;

endpackage

>>> hdl/tcrr_ram.sv
module tcrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/tcrr_mod_unit.sv
module tcrr_mod_unit #(
    parameter int COLUMNS = tcrr_pkg::COLUMNS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tcrr_pkg::COL_W-1:0] i_dividend,
    output logic                       o_done,
    output logic [$clog2(COLUMNS)-1:0] o_rem
);
    import tcrr_pkg::*;

    localparam int SLOT_W  = $clog2(COLUMNS);
    localparam int SHIFT   = COL_W + SLOT_W;
    localparam int RECIP_W = COL_W + 1;
    localparam int PROD_W  = COL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));

    logic              r_stage;
    logic              r_done;
    logic [COL_W-1:0]  r_div;
    logic [COL_W-1:0]  r_quot;
    logic [SLOT_W-1:0] r_rem;
    logic [PROD_W-1:0] product;
    logic [COL_W-1:0]  back;
    logic [SLOT_W-1:0] n_rem;

    always_comb begin
        product = PROD_W'(i_dividend) * PROD_W'(RECIP);
        back    = r_quot * COL_W'(COLUMNS);
        n_rem   = SLOT_W'(r_div - back);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_dividend;
            r_quot <= COL_W'(product >> SHIFT);
        end
        if (r_stage) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> hdl/tile_column_ring_refresher.sv
// channel | dir | handshake                  | payload
// in      | in  | i_in_valid / o_in_ready    | i_in_item  (t_in_item, one frame)
// out     | out | o_out_valid / i_out_ready  | o_out_item (t_out_item, one per slot)
// cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A frame runs these steps when results are taken at once: the accept,
// the remainder unit's registered steps (reciprocal multiply, then
// multiply back and subtract) for the starting slot, then a read and an
// evaluate step per slot on the column store (one write, one read port).
// Output stalls hold the evaluate cycle; the next frame is taken once the last
// slot is evaluated, while its result may still wait in the output register.
// Reset resets control, previous-frame state and the config registers;
// the column store is not cleared, the first frame always reloads every slot.
module tile_column_ring_refresher #(
    parameter int COLUMNS = tcrr_pkg::COLUMNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tcrr_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tcrr_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcrr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcrr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcrr_pkg::*;

    localparam int SLOT_W = $clog2(COLUMNS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(COLUMNS - 1);

    t_state r_state, n_state;

    logic [BUDGET_W-1:0] r_reload_budget;
    logic [SPRITE_W-1:0] r_first_sprite;

    logic               r_first_frame;
    logic [ROW_W-1:0]   r_prev_row;
    logic [TAG_W-1:0]   r_prev_level;
    logic [TAG_W-1:0]   r_prev_doors;

    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [FINE_W-1:0]   r_fine_x;
    logic [FINE_W-1:0]   r_fine_y;
    logic                r_full;
    logic [BUDGET_W-1:0] r_budget;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_order;

    logic      r_out_valid;
    t_out_item r_out_item;

    logic in_accept;
    logic mod_start;
    logic mod_done;
    logic ram_rd;
    logic eval_fire;
    logic [SLOT_W-1:0] mod_rem;

    logic [COL_W-1:0]    in_col;
    logic [ROW_W-1:0]    in_row;
    logic                in_full;
    logic [MAPCOL_W-1:0] held;
    logic [MAPCOL_W-1:0] want;
    logic                stale;
    logic                do_reload;
    logic                shown;
    logic                out_free;
    t_out_item           n_out_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload_budget <= BUDGET_RST;
            r_first_sprite  <= SPRITE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RELOAD_BUDGET: r_reload_budget <= i_cfg_data[BUDGET_W-1:0];
                CFG_FIRST_SPRITE:  r_first_sprite  <= i_cfg_data[SPRITE_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_col  = i_in_item.camera_x[CAM_W-1:FINE_W];
    assign in_row  = i_in_item.camera_y[CAM_W-1:FINE_W];
    assign in_full = r_first_frame || (in_row != r_prev_row)
                     || (i_in_item.level_tag != r_prev_level)
                     || (i_in_item.doors_open != r_prev_doors);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_MOD;
            S_MOD:  if (mod_done) n_state = S_READ;
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (out_free) begin
                    n_state = (r_order == LAST_SLOT) ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_rd     = 1'b0;
        eval_fire  = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_READ:  ram_rd = 1'b1;
            S_EVAL:  eval_fire = out_free;
            default: ;
        endcase
    end

    assign in_accept = i_in_valid && o_in_ready;
    assign mod_start = in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    tcrr_mod_unit #(
        .COLUMNS (COLUMNS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (in_col),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign want = MAPCOL_W'(r_col) + MAPCOL_W'(r_order);

    tcrr_ram #(
        .WIDTH (MAPCOL_W),
        .DEPTH (COLUMNS)
    ) u_held (
        .i_clk     (i_clk),
        .i_wr_en   (eval_fire && do_reload),
        .i_wr_addr (r_slot),
        .i_wr_data (want),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_slot),
        .o_rd_data (held)
    );

    always_comb begin
        stale     = r_full || (held != want);
        do_reload = stale && (r_full || (r_budget != '0));
        shown     = !stale || do_reload;

        n_out_item.reload        = do_reload;
        n_out_item.visible       = shown;
        n_out_item.sprite_number = r_first_sprite + SPRITE_W'(r_slot);
        n_out_item.map_column    = do_reload ? want : held;
        n_out_item.map_row       = r_row;
        n_out_item.last          = (r_order == LAST_SLOT);
        if (shown) begin
            n_out_item.y_word = {Y_BASE + POS_W'(r_fine_y), ROWS_FIELD};
            n_out_item.x_word = {POS_W'({r_order, 4'b0000}) - POS_W'(r_fine_x), 7'b0};
        end else begin
            n_out_item.y_word = '0;
            n_out_item.x_word = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_frame <= 1'b1;
            r_prev_row    <= '0;
            r_prev_level  <= '0;
            r_prev_doors  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_first_frame <= 1'b0;
                r_prev_row    <= in_row;
                r_prev_level  <= i_in_item.level_tag;
                r_prev_doors  <= i_in_item.doors_open;
            end
            if (eval_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col    <= in_col;
            r_row    <= in_row;
            r_fine_x <= i_in_item.camera_x[FINE_W-1:0];
            r_fine_y <= i_in_item.camera_y[FINE_W-1:0];
            r_full   <= in_full;
            r_budget <= r_reload_budget;
        end
        if (mod_done) begin
            r_slot  <= mod_rem;
            r_order <= '0;
        end
        if (eval_fire) begin
            r_out_item <= n_out_item;
            r_order    <= r_order + SLOT_W'(1);
            r_slot     <= (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
            if (do_reload && (r_budget != '0)) begin
                r_budget <= r_budget - BUDGET_W'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hdl/tcrr_checker.sv
module tcrr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tcrr_pkg::t_out_item o_out_item
);
    import tcrr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error;

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.visible |->
            (o_out_item.y_word == '0) && (o_out_item.x_word == '0))
        else $error;

    a_reload_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.reload |-> o_out_item.visible)
        else $error;

endmodule

bind tile_column_ring_refresher tcrr_checker u_tcrr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
